### hdl/hmps_pkg.sv
`default_nettype none

package hmps_pkg;

  localparam int DEF_MAX_GRID_X = 32;
  localparam int DEF_MAX_GRID_Z = 32;
  localparam int DEF_PHASE_BITS = 5;

  localparam int HEIGHT_W   = 10;
  localparam int TOTAL_W    = 20;
  localparam int FRAC_W     = 10;
  localparam int MEAN_W     = TOTAL_W + FRAC_W;
  localparam int DIFF_W     = MEAN_W + 2;
  localparam int Q15_W      = 16;
  localparam int ACC_W      = 48;
  localparam int HALF_W     = ACC_W / 2;
  localparam int POWER_W    = 42;
  localparam int ROUND_SHIFT = 50;
  localparam int SUM_W      = 97;
  localparam int LOG_W      = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [LOG_W-1:0] GRID_LOG2_RESET = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_X_LOG2 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z_LOG2 = 1'b1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q15_MAX     = 64'sd32767;
  localparam longint Q15_MIN     = -64'sd32768;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_MEAN,
    ST_MAC,
    ST_POWER,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SQ_HI,
    SQ_MID,
    SQ_LO
  } sq_part_t;

  function automatic int floor_log2(int v);
    int k;
    k = 0;
    while (k < 31 && (64'sd1 << (k + 1)) <= longint'(v)) k++;
    return k;
  endfunction

  // Quotient truncated toward zero, by shift and subtract; den is positive
  function automatic longint div_trunc(longint num, longint den);
    longint mag, q, r;
    mag = (num < 0) ? -num : num;
    q   = 0;
    r   = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r << 1) | ((mag >> i) & 64'sd1);
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'sd1;
      end
    end
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [Q15_W-1:0] trig_q15(int k, int pbits, bit want_sin);
    longint a, quad, x, st, ss, ct, cs, c, s, v, mag, r, mask;
    a    = 4 * longint'(k);
    mask = (64'sd1 << pbits) - 1;
    quad = a >> pbits;
    x    = ((a & mask) * Q30_HALF_PI) >> pbits;
    st = x;
    ss = x;
    ct = Q30_ONE;
    cs = Q30_ONE;
    for (longint n = 1; n <= 12; n++) begin
      st = st * x / Q30_ONE;
      st = st * x / Q30_ONE;
      st = div_trunc(-st, (2 * n) * (2 * n + 1));
      ss += st;
      ct = ct * x / Q30_ONE;
      ct = ct * x / Q30_ONE;
      ct = div_trunc(-ct, (2 * n - 1) * (2 * n));
      cs += ct;
    end
    case (quad)
      0: begin c = cs;  s = ss;  end
      1: begin c = -ss; s = cs;  end
      2: begin c = -cs; s = -ss; end
      default: begin c = ss; s = -cs; end
    endcase
    v   = want_sin ? s : c;
    mag = (v < 0) ? -v : v;
    r   = (mag + 16384) >> 15;
    if (v < 0) r = -r;
    if (r > Q15_MAX) r = Q15_MAX;
    if (r < Q15_MIN) r = Q15_MIN;
    return Q15_W'(r);
  endfunction

endpackage

`default_nettype wire

### hdl/hmps_ram.sv
`default_nettype none

module hmps_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic [AW-1:0]          raddr,
  output      logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/hmps_power.sv
`default_nettype none

module hmps_power
  import hmps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [ACC_W-1:0]   re,
  input  wire logic [ACC_W-1:0]   im,
  output      logic               done,
  output      logic [POWER_W-1:0] power
);

  logic               busy;
  logic               sel_im;
  sq_part_t           part;
  logic [ACC_W-1:0]   mag_re;
  logic [ACC_W-1:0]   mag_im;
  logic [ACC_W-1:0]   mag;
  logic [HALF_W-1:0]  opa;
  logic [HALF_W-1:0]  opb;
  logic [ACC_W-1:0]   prod;
  sq_part_t           prod_part;
  logic               prod_valid;
  logic               prod_last;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   addend;

  always_comb begin
    mag = sel_im ? mag_im : mag_re;
    case (part)
      SQ_HI:   begin opa = mag[ACC_W-1:HALF_W]; opb = mag[ACC_W-1:HALF_W]; end
      SQ_MID:  begin opa = mag[ACC_W-1:HALF_W]; opb = mag[HALF_W-1:0];     end
      SQ_LO:   begin opa = mag[HALF_W-1:0];     opb = mag[HALF_W-1:0];     end
      default: begin opa = '0;                  opb = '0;                  end
    endcase
  end

  always_comb begin
    case (prod_part)
      SQ_HI:   addend = SUM_W'(prod) << ACC_W;
      SQ_MID:  addend = SUM_W'(prod) << (HALF_W + 1);
      SQ_LO:   addend = SUM_W'(prod);
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      prod_valid <= 1'b0;
      done       <= 1'b0;
      sel_im     <= 1'b0;
      part       <= SQ_HI;
    end else begin
      done       <= prod_valid && prod_last;
      prod_valid <= busy;
      if (start) begin
        busy   <= 1'b1;
        sel_im <= 1'b0;
        part   <= SQ_HI;
      end else if (busy) begin
        case (part)
          SQ_HI:  part <= SQ_MID;
          SQ_MID: part <= SQ_LO;
          default: begin
            part   <= SQ_HI;
            sel_im <= 1'b1;
            if (sel_im) begin
              busy <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_re <= re[ACC_W-1] ? (ACC_W'(0) - re) : re;
      mag_im <= im[ACC_W-1] ? (ACC_W'(0) - im) : im;
      sum    <= SUM_W'(1) << (ROUND_SHIFT - 1);
    end else if (prod_valid) begin
      sum <= sum + addend;
    end
    prod      <= ACC_W'(opa) * ACC_W'(opb);
    prod_part <= part;
    prod_last <= sel_im && (part == SQ_LO);
  end

  assign power = (|sum[SUM_W-1:POWER_W+ROUND_SHIFT]) ? {POWER_W{1'b1}}
                                                      : sum[POWER_W+ROUND_SHIFT-1:ROUND_SHIFT];

endmodule

`default_nettype wire

### hdl/height_map_power_spectrum.sv
`default_nettype none

// Height map power spectrum engine.
// Input channel (in_valid/in_ready): action selects a cell load or a bin query.
// A load writes height_half at (cell_x, cell_z) when it is accepted and gives
// no result; a cell outside the store is dropped. A query returns one
// transaction on the output channel (out_valid/out_ready) with power and status.
// A query scans the Lx*Lz cells of the configured grid twice through the one
// read port of the height store: once for the height total, once through the
// multiply-accumulate stage. A bin outside the grid returns status 1 and
// power 0 without a scan. One item is in work at a time; in_ready is low until
// the result is in the output register. The output register holds a result
// while out_ready is low; the next item is taken meanwhile and its result waits
// until the register is free. Configuration (cfg_we, cfg_index, cfg_data) sets
// grid_x_log2 and grid_z_log2 and must be written only while idle; the block
// itself does not enforce this. After reset the store's MAX_GRID_X*MAX_GRID_Z
// cells (1024 by default) are cleared before in_ready rises.
module height_map_power_spectrum
  import hmps_pkg::*;
#(
  parameter int MAX_GRID_X = DEF_MAX_GRID_X,
  parameter int MAX_GRID_Z = DEF_MAX_GRID_Z,
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [LOG_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic                   action,
  input  wire logic [4:0]             cell_x,
  input  wire logic [4:0]             cell_z,
  input  wire logic [HEIGHT_W-1:0]    height_half,
  input  wire logic signed [5:0]      freq_x,
  input  wire logic [4:0]             freq_z,
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic [POWER_W-1:0]     power,
  output      logic                   status
);

  localparam int XW     = (MAX_GRID_X > 1) ? $clog2(MAX_GRID_X) : 1;
  localparam int ZW     = (MAX_GRID_Z > 1) ? $clog2(MAX_GRID_Z) : 1;
  localparam int DEPTH  = MAX_GRID_X * MAX_GRID_Z;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LX_MAX = floor_log2(MAX_GRID_X);
  localparam int LZ_MAX = floor_log2(MAX_GRID_Z);
  localparam int TAB_N  = 1 << PHASE_BITS;
  localparam int PW     = PHASE_BITS;

  logic signed [Q15_W-1:0] cos_tab [TAB_N];
  logic signed [Q15_W-1:0] sin_tab [TAB_N];

  for (genvar k = 0; k < TAB_N; k++) begin : g_tab
    localparam logic signed [Q15_W-1:0] COS_V = trig_q15(k, PHASE_BITS, 1'b0);
    localparam logic signed [Q15_W-1:0] SIN_V = trig_q15(k, PHASE_BITS, 1'b1);
    assign cos_tab[k] = COS_V;
    assign sin_tab[k] = SIN_V;
  end

  state_t state;
  state_t state_next;

  logic [LOG_W-1:0]      grid_x_log2;
  logic [LOG_W-1:0]      grid_z_log2;
  logic [LOG_W:0]        lx;
  logic [LOG_W:0]        lz;
  logic [LOG_W+1:0]      lsum;
  logic [XW-1:0]         gx_m1;
  logic [ZW-1:0]         gz_m1;

  logic [AW-1:0]         clr_addr;
  logic                  clr_last;

  logic [5:0]            nx_abs;
  logic [XW+5:0]         nx_wide;
  logic [ZW+4:0]         nz_wide;
  logic                  out_of_range;
  logic                  load_in_store;
  logic [AW-1:0]         load_addr;

  logic [XW-1:0]         mx;
  logic [ZW-1:0]         mz;
  logic                  scan_on;
  logic [XW-1:0]         sx;
  logic [ZW-1:0]         sz;
  logic [XW-1:0]         rx;
  logic [ZW-1:0]         rz;
  logic [AW-1:0]         saddr;
  logic [AW-1:0]         srow;
  logic                  scan_last;
  logic [PW-1:0]         px;
  logic [PW-1:0]         pz;

  logic                  p1_valid;
  logic                  p1_last;
  logic [PW-1:0]         p1_ph;
  logic signed [DIFF_W-1:0] diff;
  logic                  p2_valid;
  logic                  p2_last;
  logic signed [ACC_W-1:0] p2_re;
  logic signed [ACC_W-1:0] p2_im;
  logic                  acc_done;

  logic [TOTAL_W-1:0]    total;
  logic [MEAN_W-1:0]     mean;
  logic [ACC_W-1:0]      acc_re;
  logic [ACC_W-1:0]      acc_im;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [HEIGHT_W-1:0]   ram_wdata;
  logic [HEIGHT_W-1:0]   ram_rdata;

  logic                  scan_start;
  logic                  q_reject;
  logic                  pw_start;
  logic                  pw_done;
  logic [POWER_W-1:0]    pw_power;
  logic                  out_load;
  logic [POWER_W-1:0]    res_power;
  logic                  res_status;

  always_comb begin
    lx    = ({1'b0, grid_x_log2} > (LOG_W+1)'(LX_MAX)) ? (LOG_W+1)'(LX_MAX)
                                                       : {1'b0, grid_x_log2};
    lz    = ({1'b0, grid_z_log2} > (LOG_W+1)'(LZ_MAX)) ? (LOG_W+1)'(LZ_MAX)
                                                       : {1'b0, grid_z_log2};
    lsum  = (LOG_W+2)'(lx) + (LOG_W+2)'(lz);
    gx_m1 = XW'((32'd1 << lx) - 32'd1);
    gz_m1 = ZW'((32'd1 << lz) - 32'd1);
  end

  always_comb begin
    nx_abs        = freq_x[5] ? (6'd0 - freq_x) : freq_x;
    nx_wide       = (XW+6)'(freq_x);
    nz_wide       = {ZW'(0), freq_z};
    out_of_range  = (32'(nx_abs) > 32'(gx_m1)) || (32'(freq_z) > 32'(gz_m1));
    load_in_store = (32'(cell_x) < MAX_GRID_X) && (32'(cell_z) < MAX_GRID_Z);
    load_addr     = AW'(32'(cell_x) * MAX_GRID_Z + 32'(cell_z));
    clr_last      = (clr_addr == AW'(DEPTH - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_x_log2 <= GRID_LOG2_RESET;
      grid_z_log2 <= GRID_LOG2_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_X_LOG2: grid_x_log2 <= cfg_data;
        REG_GRID_Z_LOG2: grid_z_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    scan_start = 1'b0;
    q_reject   = 1'b0;
    pw_start   = 1'b0;
    out_load   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = load_addr;
    ram_wdata  = height_half;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action == ACT_LOAD) begin
            ram_we = load_in_store;
          end else if (out_of_range) begin
            q_reject   = 1'b1;
            state_next = ST_OUT;
          end else begin
            scan_start = 1'b1;
            state_next = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (p1_valid && p1_last) begin
          state_next = ST_MEAN;
        end
      end
      ST_MEAN: begin
        scan_start = 1'b1;
        state_next = ST_MAC;
      end
      ST_MAC: begin
        if (acc_done) begin
          pw_start   = 1'b1;
          state_next = ST_POWER;
        end
      end
      ST_POWER: begin
        if (pw_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Cell scan: address, row/column counters and running phase products
  always_comb begin
    scan_last = (sx == gx_m1) && (sz == gz_m1);
    px        = PW'({rx, PW'(0)} >> lx);
    pz        = PW'({rz, PW'(0)} >> lz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_on <= 1'b0;
    end else if (scan_start) begin
      scan_on <= 1'b1;
    end else if (scan_on && scan_last) begin
      scan_on <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      mx <= nx_wide[XW-1:0] & gx_m1;
      mz <= nz_wide[ZW-1:0] & gz_m1;
    end
    if (scan_start) begin
      sx    <= '0;
      sz    <= '0;
      rx    <= '0;
      rz    <= '0;
      saddr <= '0;
      srow  <= '0;
    end else if (scan_on) begin
      if (sz == gz_m1) begin
        sz    <= '0;
        rz    <= '0;
        sx    <= sx + XW'(1);
        rx    <= (rx + mx) & gx_m1;
        srow  <= srow + AW'(MAX_GRID_Z);
        saddr <= srow + AW'(MAX_GRID_Z);
      end else begin
        sz    <= sz + ZW'(1);
        rz    <= (rz + mz) & gz_m1;
        saddr <= saddr + AW'(1);
      end
    end
  end

  hmps_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (saddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      p1_valid <= scan_on;
      p2_valid <= p1_valid && (state == ST_MAC);
      acc_done <= p2_valid && p2_last;
    end
  end

  assign diff = $signed({(DIFF_W-HEIGHT_W-FRAC_W)'(0), ram_rdata, FRAC_W'(0)})
              - $signed({2'b00, mean});

  always_ff @(posedge clk) begin
    p1_last <= scan_last;
    p1_ph   <= px + pz;
    p2_last <= p1_last;
    p2_re   <= ACC_W'(diff) * ACC_W'(cos_tab[p1_ph]);
    p2_im   <= ACC_W'(diff) * ACC_W'(sin_tab[p1_ph]);
  end

  always_ff @(posedge clk) begin
    if (scan_start && (state == ST_IDLE)) begin
      total <= '0;
    end else if (p1_valid && (state == ST_SUM)) begin
      total <= total + TOTAL_W'(ram_rdata);
    end
    if (state == ST_MEAN) begin
      mean   <= MEAN_W'({total, FRAC_W'(0)} >> lsum);
      acc_re <= '0;
      acc_im <= '0;
    end else if (p2_valid) begin
      acc_re <= acc_re + p2_re;
      acc_im <= acc_im + p2_im;
    end
  end

  hmps_power u_power (
    .clk   (clk),
    .rst   (rst),
    .start (pw_start),
    .re    (acc_re),
    .im    (acc_im),
    .done  (pw_done),
    .power (pw_power)
  );

  always_ff @(posedge clk) begin
    if (q_reject) begin
      res_power  <= '0;
      res_status <= 1'b1;
    end else if (pw_done) begin
      res_power  <= pw_power;
      res_status <= 1'b0;
    end
    if (out_load) begin
      power  <= res_power;
      status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
